>>> rtl/core/gtl_pkg.sv
package gtl_pkg;

    // character codes
    localparam logic [7:0] C_NEWLINE  = 8'd10;
    localparam logic [7:0] C_TBL_BASE = 8'd182;
    localparam logic [7:0] C_QUOTE_T  = 8'd39;
    localparam logic [7:0] C_QUOTE_D  = 8'd34;

    // Greek letters that take part in the held-letter rules
    localparam logic [7:0] C_GR_UM = 8'd204;
    localparam logic [7:0] C_GR_LM = 8'd236;
    localparam logic [7:0] C_GR_UN = 8'd205;
    localparam logic [7:0] C_GR_LN = 8'd237;
    localparam logic [7:0] C_GR_UP = 8'd208;
    localparam logic [7:0] C_GR_LP = 8'd240;
    localparam logic [7:0] C_GR_UT = 8'd212;
    localparam logic [7:0] C_GR_LT = 8'd244;

    // Latin bytes for a flushed or paired held letter
    localparam logic [7:0] C_LAT_UM = 8'd77;
    localparam logic [7:0] C_LAT_LM = 8'd109;
    localparam logic [7:0] C_LAT_UN = 8'd78;
    localparam logic [7:0] C_LAT_LN = 8'd110;
    localparam logic [7:0] C_LAT_UB = 8'd66;
    localparam logic [7:0] C_LAT_LB = 8'd98;
    localparam logic [7:0] C_LAT_UD = 8'd68;
    localparam logic [7:0] C_LAT_LD = 8'd100;

    // most bytes one input can cause
    localparam int unsigned C_MAX_BYTES = 4;

    // one input's output bytes, first in bytes[0]
    typedef struct packed {
        logic [C_MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                  len;
    } t_desc;

    // Greek row lookup: {first, second, third}, zero means no byte.
    // The empty cell and every byte outside the Greek range give all zeros.
    function automatic logic [23:0] f_xlat(input logic [7:0] x);
        logic [23:0] r;
        unique case (x)
            8'd182: r = {C_QUOTE_T, 8'd65, 8'd0};
            8'd183: r = {8'd183, 8'd0, 8'd0};
            8'd184: r = {C_QUOTE_T, 8'd69, 8'd0};
            8'd185: r = {C_QUOTE_T, 8'd72, 8'd0};
            8'd186: r = {C_QUOTE_T, 8'd73, 8'd0};
            8'd187: r = {8'd187, 8'd0, 8'd0};
            8'd188: r = {C_QUOTE_T, 8'd79, 8'd0};
            8'd189: r = {8'd189, 8'd0, 8'd0};
            8'd190: r = {C_QUOTE_T, 8'd89, 8'd0};
            8'd191: r = {C_QUOTE_T, 8'd87, 8'd0};
            8'd192: r = {8'd105, C_QUOTE_T, C_QUOTE_D};
            8'd193: r = {8'd65, 8'd0, 8'd0};
            8'd194: r = {8'd86, 8'd0, 8'd0};
            8'd195: r = {8'd71, 8'd0, 8'd0};
            8'd196: r = {8'd68, 8'd0, 8'd0};
            8'd197: r = {8'd69, 8'd0, 8'd0};
            8'd198: r = {8'd90, 8'd0, 8'd0};
            8'd199: r = {8'd72, 8'd0, 8'd0};
            8'd200: r = {8'd56, 8'd0, 8'd0};
            8'd201: r = {8'd73, 8'd0, 8'd0};
            8'd202: r = {8'd75, 8'd0, 8'd0};
            8'd203: r = {8'd76, 8'd0, 8'd0};
            8'd204: r = {8'd77, 8'd0, 8'd0};
            8'd205: r = {8'd78, 8'd0, 8'd0};
            8'd206: r = {8'd75, 8'd83, 8'd0};
            8'd207: r = {8'd79, 8'd0, 8'd0};
            8'd208: r = {8'd80, 8'd0, 8'd0};
            8'd209: r = {8'd82, 8'd0, 8'd0};
            8'd211: r = {8'd83, 8'd0, 8'd0};
            8'd212: r = {8'd84, 8'd0, 8'd0};
            8'd213: r = {8'd89, 8'd0, 8'd0};
            8'd214: r = {8'd70, 8'd0, 8'd0};
            8'd215: r = {8'd88, 8'd0, 8'd0};
            8'd216: r = {8'd80, 8'd83, 8'd0};
            8'd217: r = {8'd87, 8'd0, 8'd0};
            8'd218: r = {8'd73, C_QUOTE_D, 8'd0};
            8'd219: r = {8'd89, C_QUOTE_D, 8'd0};
            8'd220: r = {8'd97, C_QUOTE_T, 8'd0};
            8'd221: r = {8'd101, C_QUOTE_T, 8'd0};
            8'd222: r = {8'd104, C_QUOTE_T, 8'd0};
            8'd223: r = {8'd105, C_QUOTE_T, 8'd0};
            8'd224: r = {8'd121, C_QUOTE_T, C_QUOTE_D};
            8'd225: r = {8'd97, 8'd0, 8'd0};
            8'd226: r = {8'd118, 8'd0, 8'd0};
            8'd227: r = {8'd103, 8'd0, 8'd0};
            8'd228: r = {8'd100, 8'd0, 8'd0};
            8'd229: r = {8'd101, 8'd0, 8'd0};
            8'd230: r = {8'd122, 8'd0, 8'd0};
            8'd231: r = {8'd104, 8'd0, 8'd0};
            8'd232: r = {8'd56, 8'd0, 8'd0};
            8'd233: r = {8'd105, 8'd0, 8'd0};
            8'd234: r = {8'd107, 8'd0, 8'd0};
            8'd235: r = {8'd108, 8'd0, 8'd0};
            8'd236: r = {8'd109, 8'd0, 8'd0};
            8'd237: r = {8'd110, 8'd0, 8'd0};
            8'd238: r = {8'd107, 8'd115, 8'd0};
            8'd239: r = {8'd111, 8'd0, 8'd0};
            8'd240: r = {8'd112, 8'd0, 8'd0};
            8'd241: r = {8'd114, 8'd0, 8'd0};
            8'd242: r = {8'd115, 8'd0, 8'd0};
            8'd243: r = {8'd115, 8'd0, 8'd0};
            8'd244: r = {8'd116, 8'd0, 8'd0};
            8'd245: r = {8'd121, 8'd0, 8'd0};
            8'd246: r = {8'd102, 8'd0, 8'd0};
            8'd247: r = {8'd120, 8'd0, 8'd0};
            8'd248: r = {8'd112, 8'd115, 8'd0};
            8'd249: r = {8'd119, 8'd0, 8'd0};
            8'd250: r = {8'd105, C_QUOTE_D, 8'd0};
            8'd251: r = {8'd121, C_QUOTE_D, 8'd0};
            8'd252: r = {8'd111, C_QUOTE_T, 8'd0};
            8'd253: r = {8'd121, C_QUOTE_T, 8'd0};
            8'd254: r = {8'd119, C_QUOTE_T, 8'd0};
            default: r = 24'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/gtl_front.sv
module gtl_front
    import gtl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  logic  [7:0] i_in_byte,
    input  logic  i_q_full,
    output logic  o_q_push,
    output t_desc o_q_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UM   = 5'b00010,
        S_LM   = 5'b00100,
        S_UN   = 5'b01000,
        S_LN   = 5'b10000
    } t_hold;

    t_hold       r_mode;
    t_hold       n_mode;
    t_desc       desc;
    logic        accept;
    logic        held;
    logic        hit;
    logic [7:0]  flush_b;
    logic [7:0]  pair_b;
    logic [23:0] row;
    logic [7:0]  p0, p1, p2;
    logic [2:0]  plen;
    logic [2:0]  blen;
    logic        hold_letter;
    t_hold       hold_mode;

    assign accept = i_push && !i_q_full;

    // held-letter bytes and the letters that pair with it
    always_comb begin
        flush_b = 8'd0;
        pair_b  = 8'd0;
        hit     = 1'b0;
        unique case (r_mode)
            S_UM: begin
                flush_b = C_LAT_UM;
                pair_b  = C_LAT_UB;
                hit     = (i_in_byte == C_GR_UP) || (i_in_byte == C_GR_LP);
            end
            S_LM: begin
                flush_b = C_LAT_LM;
                pair_b  = C_LAT_LB;
                hit     = (i_in_byte == C_GR_UP) || (i_in_byte == C_GR_LP);
            end
            S_UN: begin
                flush_b = C_LAT_UN;
                pair_b  = C_LAT_UD;
                hit     = (i_in_byte == C_GR_UT) || (i_in_byte == C_GR_LT);
            end
            S_LN: begin
                flush_b = C_LAT_LN;
                pair_b  = C_LAT_LD;
                hit     = (i_in_byte == C_GR_UT) || (i_in_byte == C_GR_LT);
            end
            default: begin
                flush_b = 8'd0;
                pair_b  = 8'd0;
                hit     = 1'b0;
            end
        endcase
    end

    // plain character: pass-through below the Greek range, table above it
    always_comb begin
        row = f_xlat(i_in_byte);
        if (i_in_byte < C_TBL_BASE) begin
            p0   = i_in_byte;
            p1   = 8'd0;
            p2   = 8'd0;
            plen = 3'd1;
        end else begin
            p0 = row[23:16];
            p1 = row[15:8];
            p2 = row[7:0];
            priority if (p0 == 8'd0) begin
                plen = 3'd0;
            end else if (p1 == 8'd0) begin
                plen = 3'd1;
            end else if (p2 == 8'd0) begin
                plen = 3'd2;
            end else begin
                plen = 3'd3;
            end
        end
    end

    // letters that get held back
    always_comb begin
        hold_letter = 1'b1;
        hold_mode   = S_IDLE;
        priority if (i_in_byte == C_GR_UM) begin
            hold_mode = S_UM;
        end else if (i_in_byte == C_GR_LM) begin
            hold_mode = S_LM;
        end else if (i_in_byte == C_GR_UN) begin
            hold_mode = S_UN;
        end else if (i_in_byte == C_GR_LN) begin
            hold_mode = S_LN;
        end else begin
            hold_letter = 1'b0;
        end
    end

    // classify the byte into a list of output bytes
    always_comb begin
        held   = (r_mode == S_UM) || (r_mode == S_LM) || (r_mode == S_UN) || (r_mode == S_LN);
        desc   = '0;
        n_mode = r_mode;
        blen   = hold_letter ? 3'd0 : plen;
        if (i_in_byte == C_NEWLINE) begin
            // newline keeps whatever is held
            desc.bytes[0] = C_NEWLINE;
            desc.len      = 3'd1;
        end else if (held && hit) begin
            desc.bytes[0] = pair_b;
            desc.len      = 3'd1;
            n_mode        = S_IDLE;
        end else begin
            n_mode = hold_mode;
            if (held) begin
                desc.bytes[0] = flush_b;
                desc.bytes[1] = p0;
                desc.bytes[2] = p1;
                desc.bytes[3] = p2;
                desc.len      = blen + 3'd1;
            end else begin
                desc.bytes[0] = p0;
                desc.bytes[1] = p1;
                desc.bytes[2] = p2;
                desc.len      = blen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= S_IDLE;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

    // bytes that produce nothing do not enter the queue
    assign o_q_push = accept && (desc.len != 3'd0);
    assign o_q_data = desc;

endmodule

>>> rtl/core/gtl_fifo.sv
module gtl_fifo
    import gtl_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_desc i_wr_data,
    output logic  o_full,
    input  logic  i_rd,
    output logic  o_valid,
    output t_desc o_rd_data
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_desc         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          wr_en, rd_en;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && o_valid;

    // pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue occupancy beyond depth");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("transfer into a full queue");
`endif

endmodule

>>> rtl/core/gtl_back.sv
module gtl_back
    import gtl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_desc      i_q_data,
    output logic       o_q_rd,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    t_desc      r_desc, n_desc;
    logic       r_busy, n_busy;
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;
    logic       out_free;
    logic       take;
    logic       cur_last;
    logic       load;

    // step through the current list one byte per transfer
    always_comb begin
        out_free = !r_out_valid || i_pop;
        cur_last = ({1'b0, r_idx} == (r_desc.len - 3'd1));
        take     = r_busy && out_free;
        load     = i_q_valid && (!r_busy || (take && cur_last));

        n_desc      = r_desc;
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (take) begin
            n_out_valid = 1'b1;
            n_out_byte  = r_desc.bytes[r_idx];
            n_out_last  = cur_last;
            n_idx       = r_idx + 2'd1;
            if (cur_last) begin
                n_busy = 1'b0;
            end
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end

        if (load) begin
            n_desc = i_q_data;
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc     <= n_desc;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_q_rd     = load;
    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

`ifndef SYNTH
    a_idx_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({1'b0, r_idx} < r_desc.len))
        else $error("byte index past end of list");
    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_desc.len != 3'd0) && (r_desc.len <= 3'(C_MAX_BYTES)))
        else $error("list length out of range");
`endif

endmodule

>>> rtl/core/greek_to_latin_transliterator.sv
// An accepted byte goes into the queue, then into the output side's list register, and its
// first Latin byte then into the output register. One input byte per cycle is taken while
// the queue has room; output moves one byte per cycle while popped; items yield 0 to 4 bytes.
// Decode queue depth QUEUE_DEPTH lets the input side run ahead of the output side.
// Reset (synchronous, active low) clears the held letter, the queue and the output register.
module greek_to_latin_transliterator
    import gtl_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic  q_full;
    logic  q_push;
    t_desc q_wr_data;
    logic  q_valid;
    logic  q_rd;
    t_desc q_rd_data;

    assign full = q_full;

    // classify and track the held letter
    gtl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_in_byte (i_in_byte),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_data  (q_wr_data)
    );

    // decoupling queue of byte lists
    gtl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_push),
        .i_wr_data (q_wr_data),
        .o_full    (q_full),
        .i_rd      (q_rd),
        .o_valid   (q_valid),
        .o_rd_data (q_rd_data)
    );

    // serialise lists onto the result port
    gtl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_rd_data),
        .o_q_rd     (q_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule
